// ----- hdl/via_pkg.sv -----
`default_nettype none

package via_pkg;

   // item kinds
   localparam logic [1:0] MODE_READ   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_SAMPLE = 2'd2;
   localparam logic [1:0] MODE_TICK   = 2'd3;

   // register map
   localparam logic [3:0] REG_ORB   = 4'd0;
   localparam logic [3:0] REG_ORA   = 4'd1;
   localparam logic [3:0] REG_DDRB  = 4'd2;
   localparam logic [3:0] REG_DDRA  = 4'd3;
   localparam logic [3:0] REG_T1CL  = 4'd4;
   localparam logic [3:0] REG_T1CH  = 4'd5;
   localparam logic [3:0] REG_T1LL  = 4'd6;
   localparam logic [3:0] REG_T1LH  = 4'd7;
   localparam logic [3:0] REG_T2CL  = 4'd8;
   localparam logic [3:0] REG_T2CH  = 4'd9;
   localparam logic [3:0] REG_SR    = 4'd10;
   localparam logic [3:0] REG_ACR   = 4'd11;
   localparam logic [3:0] REG_PCR   = 4'd12;
   localparam logic [3:0] REG_IFR   = 4'd13;
   localparam logic [3:0] REG_IER   = 4'd14;
   localparam logic [3:0] REG_ORA_NH = 4'd15;

   // interrupt flag masks
   localparam logic [6:0] FLAG_CA2 = 7'h01;
   localparam logic [6:0] FLAG_CA1 = 7'h02;
   localparam logic [6:0] FLAG_CB2 = 7'h08;
   localparam logic [6:0] FLAG_CB1 = 7'h10;
   localparam logic [6:0] FLAG_T2  = 7'h20;
   localparam logic [6:0] FLAG_T1  = 7'h40;

   // pending handshake actions
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_LOW  = 2'd1;
   localparam logic [1:0] ACT_HIGH = 2'd2;

   // ca2/cb2 control field codes
   localparam logic [2:0] C2_IN_NEG   = 3'd0;
   localparam logic [2:0] C2_IN_POS   = 3'd2;
   localparam logic [2:0] C2_HANDSHK  = 3'd4;
   localparam logic [2:0] C2_PULSE    = 3'd5;
   localparam logic [2:0] C2_MAN_LOW  = 3'd6;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
      logic       ca2_out;
      logic       cb2_out;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/via_6522_register_interface.sv -----
// Register side of a 6522-style interface adapter.
// Request channel (req_valid/req_ready) carries one word per item: a bus read,
// a bus write, a CA1/CB1 pin sample or a tick that applies pending CA2/CB2
// handshake changes. Every request yields exactly one response word on the
// rsp_valid/rsp_ready channel: read data (zero unless a read), the irq level,
// the port drive values and the CA2/CB2 levels after the item.
// The register state and the response register are both loaded at the edge
// that accepts the request. Throughput is one item per clock while the receiver
// takes each response; the single response register is the only buffering.
// When the receiver stalls, the response register holds its word and
// req_ready follows rsp_ready, so a new request is taken in the same cycle the
// held response leaves.
// Synchronous reset clears all state registers but the response word to zero,
// save CA2/CB2 and last CA1/CB1 levels (high); no pending handshake, no response.
`default_nettype none

module via_6522_register_interface (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_mode,
   input  wire logic [3:0] req_address,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_port_a_in,
   input  wire logic [7:0] req_port_b_in,
   input  wire logic       req_ca1_level,
   input  wire logic       req_cb1_level,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_irq,
   output logic [7:0]      rsp_port_a_out,
   output logic [7:0]      rsp_port_b_out,
   output logic            rsp_ca2_out,
   output logic            rsp_cb2_out
);

   logic        req_fire;
   logic        rsp_valid_ff;
   via_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]  out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [7:0]  dir_a_ff, dir_a_in, dir_b_ff, dir_b_in;
   logic [15:0] t1_cnt_ff, t1_cnt_in, t1_lat_ff, t1_lat_in;
   logic [15:0] t2_cnt_ff, t2_cnt_in, t2_lat_ff, t2_lat_in;
   logic [7:0]  sr_ff, sr_in, acr_ff, acr_in, pcr_ff, pcr_in;
   logic [6:0]  flags_ff, flags_in, en_ff, en_in;
   logic        ca2_ff, ca2_in, cb2_ff, cb2_in;
   logic        ca1_last_ff, ca1_last_in, cb1_last_ff, cb1_last_in;
   logic [1:0]  pend_ca2_ff, pend_ca2_in, pend_cb2_ff, pend_cb2_in;
   logic [7:0]  rd;
   logic [2:0]  fa, fb;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign fa = pcr_ff[3:1];
   assign fb = pcr_ff[7:5];

   always_comb begin
      out_a_in    = out_a_ff;
      out_b_in    = out_b_ff;
      dir_a_in    = dir_a_ff;
      dir_b_in    = dir_b_ff;
      t1_cnt_in   = t1_cnt_ff;
      t1_lat_in   = t1_lat_ff;
      t2_cnt_in   = t2_cnt_ff;
      t2_lat_in   = t2_lat_ff;
      sr_in       = sr_ff;
      acr_in      = acr_ff;
      pcr_in      = pcr_ff;
      flags_in    = flags_ff;
      en_in       = en_ff;
      ca2_in      = ca2_ff;
      cb2_in      = cb2_ff;
      ca1_last_in = ca1_last_ff;
      cb1_last_in = cb1_last_ff;
      pend_ca2_in = pend_ca2_ff;
      pend_cb2_in = pend_cb2_ff;
      rd          = 8'h00;

      unique case (req_mode)
         via_pkg::MODE_READ: begin
            unique case (req_address)
               via_pkg::REG_ORB: begin
                  rd = (req_port_b_in & ~dir_b_ff) | (out_b_ff & dir_b_ff);
                  if (fb == via_pkg::C2_HANDSHK) pend_cb2_in = via_pkg::ACT_LOW;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CB1 | via_pkg::FLAG_CB2);
               end
               via_pkg::REG_ORA: begin
                  rd = req_port_a_in;
                  if (fa == via_pkg::C2_HANDSHK) pend_ca2_in = via_pkg::ACT_LOW;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CA1 | via_pkg::FLAG_CA2);
               end
               via_pkg::REG_DDRB: rd = dir_b_ff;
               via_pkg::REG_DDRA: rd = dir_a_ff;
               via_pkg::REG_T1CL: begin
                  rd = t1_cnt_ff[7:0];
                  flags_in = flags_ff & ~via_pkg::FLAG_T1;
               end
               via_pkg::REG_T1CH: rd = t1_cnt_ff[15:8];
               via_pkg::REG_T1LL: rd = t1_lat_ff[7:0];
               via_pkg::REG_T1LH: rd = t1_lat_ff[15:8];
               via_pkg::REG_T2CL: begin
                  rd = t2_cnt_ff[7:0];
                  flags_in = flags_ff & ~via_pkg::FLAG_T2;
               end
               via_pkg::REG_T2CH: rd = t2_cnt_ff[15:8];
               via_pkg::REG_SR:   rd = sr_ff;
               via_pkg::REG_ACR:  rd = acr_ff;
               via_pkg::REG_PCR:  rd = pcr_ff;
               via_pkg::REG_IFR:  rd = {|(flags_ff & en_ff), flags_ff};
               via_pkg::REG_IER:  rd = {1'b0, en_ff};
               default:           rd = req_port_a_in;
            endcase
         end
         via_pkg::MODE_WRITE: begin
            unique case (req_address)
               via_pkg::REG_ORB: begin
                  out_b_in = req_write_data;
                  if (fb == via_pkg::C2_HANDSHK) pend_cb2_in = via_pkg::ACT_LOW;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CB1 | via_pkg::FLAG_CB2);
               end
               via_pkg::REG_ORA: begin
                  out_a_in = req_write_data;
                  if (fa == via_pkg::C2_HANDSHK) pend_ca2_in = via_pkg::ACT_LOW;
                  flags_in = flags_ff & ~(via_pkg::FLAG_CA1 | via_pkg::FLAG_CA2);
               end
               via_pkg::REG_DDRB: dir_b_in = req_write_data;
               via_pkg::REG_DDRA: dir_a_in = req_write_data;
               via_pkg::REG_T1CL, via_pkg::REG_T1LL:
                  t1_lat_in = {t1_lat_ff[15:8], req_write_data};
               via_pkg::REG_T1CH: begin
                  t1_lat_in = {req_write_data, t1_lat_ff[7:0]};
                  t1_cnt_in = {req_write_data, t1_lat_ff[7:0]};
                  flags_in  = flags_ff & ~via_pkg::FLAG_T1;
               end
               via_pkg::REG_T1LH: begin
                  t1_lat_in = {req_write_data, t1_lat_ff[7:0]};
                  flags_in  = flags_ff & ~via_pkg::FLAG_T1;
               end
               via_pkg::REG_T2CL: t2_lat_in = {t2_lat_ff[15:8], req_write_data};
               via_pkg::REG_T2CH: begin
                  t2_cnt_in = {req_write_data, t2_lat_ff[7:0]};
                  flags_in  = flags_ff & ~via_pkg::FLAG_T2;
               end
               via_pkg::REG_SR:  sr_in  = req_write_data;
               via_pkg::REG_ACR: acr_in = req_write_data;
               via_pkg::REG_PCR: begin
                  pcr_in = req_write_data;
                  if (fb != req_write_data[7:5]) begin
                     if (req_write_data[7:5] == via_pkg::C2_MAN_LOW) begin
                        pend_cb2_in = via_pkg::ACT_NONE;
                        cb2_in      = 1'b0;
                     end else if (req_write_data[7:5] != via_pkg::C2_HANDSHK &&
                                  req_write_data[7:5] != via_pkg::C2_PULSE) begin
                        pend_cb2_in = via_pkg::ACT_NONE;
                        cb2_in      = 1'b1;
                     end
                  end
                  if (fa != req_write_data[3:1]) begin
                     if (req_write_data[3:1] == via_pkg::C2_MAN_LOW) begin
                        pend_ca2_in = via_pkg::ACT_NONE;
                        ca2_in      = 1'b0;
                     end else if (req_write_data[3:1] != via_pkg::C2_HANDSHK &&
                                  req_write_data[3:1] != via_pkg::C2_PULSE) begin
                        pend_ca2_in = via_pkg::ACT_NONE;
                        ca2_in      = 1'b1;
                     end
                  end
               end
               via_pkg::REG_IFR: flags_in = flags_ff & ~req_write_data[6:0];
               via_pkg::REG_IER: begin
                  if (req_write_data[7]) en_in = en_ff | req_write_data[6:0];
                  else en_in = en_ff & ~req_write_data[6:0];
               end
               default: ;
            endcase
         end
         via_pkg::MODE_SAMPLE: begin
            if (req_ca1_level != ca1_last_ff) begin
               ca1_last_in = req_ca1_level;
               if (pcr_ff[0] == req_ca1_level) flags_in = flags_in | via_pkg::FLAG_CA1;
               if (fa == via_pkg::C2_HANDSHK) pend_ca2_in = via_pkg::ACT_HIGH;
            end
            if (req_cb1_level != cb1_last_ff) begin
               cb1_last_in = req_cb1_level;
               if (pcr_ff[4] == req_cb1_level) flags_in = flags_in | via_pkg::FLAG_CB1;
               if (fb == via_pkg::C2_HANDSHK) pend_cb2_in = via_pkg::ACT_HIGH;
            end
         end
         default: begin
            if (pend_ca2_ff == via_pkg::ACT_LOW) ca2_in = 1'b0;
            else if (pend_ca2_ff == via_pkg::ACT_HIGH) ca2_in = 1'b1;
            if (pend_cb2_ff == via_pkg::ACT_LOW) cb2_in = 1'b0;
            else if (pend_cb2_ff == via_pkg::ACT_HIGH) cb2_in = 1'b1;
            pend_ca2_in = via_pkg::ACT_NONE;
            pend_cb2_in = via_pkg::ACT_NONE;
         end
      endcase

      rsp_in.read_data  = rd;
      rsp_in.irq        = |(flags_in & en_in);
      rsp_in.port_a_out = out_a_in | ~dir_a_in;
      rsp_in.port_b_out = out_b_in | ~dir_b_in;
      rsp_in.ca2_out    = ca2_in;
      rsp_in.cb2_out    = cb2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_a_ff     <= '0;
         out_b_ff     <= '0;
         dir_a_ff     <= '0;
         dir_b_ff     <= '0;
         t1_cnt_ff    <= '0;
         t1_lat_ff    <= '0;
         t2_cnt_ff    <= '0;
         t2_lat_ff    <= '0;
         sr_ff        <= '0;
         acr_ff       <= '0;
         pcr_ff       <= '0;
         flags_ff     <= '0;
         en_ff        <= '0;
         ca2_ff       <= 1'b1;
         cb2_ff       <= 1'b1;
         ca1_last_ff  <= 1'b1;
         cb1_last_ff  <= 1'b1;
         pend_ca2_ff  <= via_pkg::ACT_NONE;
         pend_cb2_ff  <= via_pkg::ACT_NONE;
      end else begin
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
            out_a_ff     <= out_a_in;
            out_b_ff     <= out_b_in;
            dir_a_ff     <= dir_a_in;
            dir_b_ff     <= dir_b_in;
            t1_cnt_ff    <= t1_cnt_in;
            t1_lat_ff    <= t1_lat_in;
            t2_cnt_ff    <= t2_cnt_in;
            t2_lat_ff    <= t2_lat_in;
            sr_ff        <= sr_in;
            acr_ff       <= acr_in;
            pcr_ff       <= pcr_in;
            flags_ff     <= flags_in;
            en_ff        <= en_in;
            ca2_ff       <= ca2_in;
            cb2_ff       <= cb2_in;
            ca1_last_ff  <= ca1_last_in;
            cb1_last_ff  <= cb1_last_in;
            pend_ca2_ff  <= pend_ca2_in;
            pend_cb2_ff  <= pend_cb2_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_ff.read_data;
   assign rsp_irq        = rsp_ff.irq;
   assign rsp_port_a_out = rsp_ff.port_a_out;
   assign rsp_port_b_out = rsp_ff.port_b_out;
   assign rsp_ca2_out    = rsp_ff.ca2_out;
   assign rsp_cb2_out    = rsp_ff.cb2_out;

   a_pend_legal: assert property (@(posedge clock) disable iff (reset)
      !(pend_ca2_ff[1] && pend_ca2_ff[0]) && !(pend_cb2_ff[1] && pend_cb2_ff[0]))
      else $error("reserved pending action stored");

   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == via_pkg::MODE_TICK) |=>
      (pend_ca2_ff == via_pkg::ACT_NONE && pend_cb2_ff == via_pkg::ACT_NONE))
      else $error("pending action survived a tick");

   a_irq_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.irq == |(flags_ff & en_ff)))
      else $error("irq out of step with flags and enables");

   a_port_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.port_a_out == (out_a_ff | ~dir_a_ff) &&
                        rsp_ff.port_b_out == (out_b_ff | ~dir_b_ff)))
      else $error("port drive out of step with registers");

   a_c2_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.ca2_out == ca2_ff && rsp_ff.cb2_out == cb2_ff))
      else $error("ca2/cb2 out of step with levels");

endmodule

`default_nettype wire
